// ===== rtl/ptr_pkg.sv =====
// Package for the trace recorder: word types, op codes, register indexes
// and the command/status structs between controller and datapath.
// No dependencies.
package ptr_pkg;

  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_MARK   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [1:0] REG_TRACE_EN = 2'd0;
  localparam logic [1:0] REG_COV_EN   = 2'd1;
  localparam logic [1:0] REG_ND_EN    = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [12:0] point_id;
    logic [9:0]  read_index;
  } in_word_t;

  typedef struct packed {
    logic [12:0] read_data;
    logic [10:0] log_length;
    logic [12:0] covered_count;
    logic [12:0] nd_count;
    logic        appended;
    logic        error;
  } out_word_t;

  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } stat_t;

endpackage

// ===== rtl/ptr_ctrl.sv =====
// Controller for the trace recorder: post-reset clearing pass, item
// sequencing and the result valid flag. Depends on ptr_pkg.
module ptr_ctrl
  import ptr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_ready,
  output logic  result_valid,
  input  logic  result_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign item_ready   = (state == ST_IDLE);
  assign out_free     = !result_valid || result_ready;
  assign cmd.clear_wr = (state == ST_CLEAR);
  assign cmd.accept   = item_valid && item_ready;
  assign cmd.commit   = (state == ST_EXEC) && out_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd.accept) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (cmd.commit) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/ptr_datapath.sv =====
// Datapath for the trace recorder: config registers, bitmap and log
// memories, counters and the result register. Depends on ptr_pkg.
module ptr_datapath
  import ptr_pkg::*;
#(
  parameter int NUM_POINTS = 4096,
  parameter int LOG_DEPTH  = 1024
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic      cfg_data,
  input  in_word_t  item,
  input  cmd_t      cmd,
  output stat_t     stat,
  output out_word_t result
);

  localparam int PW = $clog2(NUM_POINTS);
  localparam int LW = $clog2(LOG_DEPTH);
  localparam int CW = $clog2(LOG_DEPTH + 1);
  localparam int TW = $clog2(NUM_POINTS + 1);

  // bit 1: nondeterministic, bit 0: covered
  logic [1:0]  bm_mem [NUM_POINTS];
  logic [12:0] log_mem [LOG_DEPTH];

  logic trace_en, cov_en, nd_en;
  logic [PW-1:0] clr_addr;
  logic [CW-1:0] log_count, log_count_next;
  logic [TW-1:0] cov_total, cov_total_next;
  logic [TW-1:0] nd_total, nd_total_next;

  logic          in_id_ok;
  logic [PW-1:0] in_slot;

  logic [1:0]    op_q;
  logic [12:0]   id_q;
  logic [9:0]    ridx_q;
  logic          id_ok_q;
  logic [PW-1:0] slot_q;
  logic [1:0]    bm_q;
  logic [12:0]   log_q;

  logic          bm_we;
  logic [PW-1:0] bm_waddr;
  logic [1:0]    bm_wdata;
  logic          log_we;
  logic          new_cov, new_nd, append, err, rd_ok;
  logic [12:0]   rdata;

  assign in_id_ok = (item.point_id != 13'd0) &&
                    (32'(item.point_id) <= NUM_POINTS);
  assign in_slot  = in_id_ok ? PW'(item.point_id - 13'd1) : '0;
  assign stat.clear_last = (clr_addr == PW'(NUM_POINTS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      trace_en <= 1'b0;
      cov_en   <= 1'b0;
      nd_en    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRACE_EN: trace_en <= cfg_data;
        REG_COV_EN:   cov_en   <= cfg_data;
        REG_ND_EN:    nd_en    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    new_cov        = 1'b0;
    new_nd         = 1'b0;
    append         = 1'b0;
    err            = 1'b0;
    rdata          = '0;
    bm_wdata       = bm_q;
    log_count_next = log_count;
    rd_ok          = (32'(ridx_q) < 32'(log_count));
    case (op_q)
      OP_RECORD: begin
        if (!id_ok_q) begin
          err = 1'b1;
        end else if (trace_en) begin
          new_cov = cov_en && !bm_q[0];
          append  = (log_count != CW'(LOG_DEPTH)) && !(nd_en && bm_q[1]);
        end
        bm_wdata = {bm_q[1], bm_q[0] | new_cov};
      end
      OP_MARK: begin
        if (!id_ok_q) err = 1'b1;
        else new_nd = !bm_q[1];
        bm_wdata = {1'b1, bm_q[0]};
      end
      OP_CLEAR: begin
        log_count_next = '0;
      end
      OP_READ: begin
        if (rd_ok) rdata = log_q;
        else err = 1'b1;
      end
      default: ;
    endcase
    if (append) log_count_next = log_count + CW'(1);
    cov_total_next = cov_total + TW'(new_cov);
    nd_total_next  = nd_total + TW'(new_nd);
  end

  assign bm_we    = cmd.clear_wr || (cmd.commit && id_ok_q &&
                    (op_q == OP_RECORD || op_q == OP_MARK));
  assign bm_waddr = cmd.clear_wr ? clr_addr : slot_q;
  assign log_we   = cmd.commit && append;

  always_ff @(posedge clk) begin
    if (bm_we) bm_mem[bm_waddr] <= cmd.clear_wr ? 2'b00 : bm_wdata;
    if (cmd.accept) bm_q <= bm_mem[in_slot];
  end

  always_ff @(posedge clk) begin
    if (log_we) log_mem[LW'(log_count)] <= id_q;
    if (cmd.accept) log_q <= log_mem[LW'(item.read_index)];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q    <= item.op;
      id_q    <= item.point_id;
      ridx_q  <= item.read_index;
      id_ok_q <= in_id_ok;
      slot_q  <= in_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      log_count <= '0;
      cov_total <= '0;
      nd_total  <= '0;
    end else begin
      if (cmd.clear_wr) clr_addr <= clr_addr + PW'(1);
      if (cmd.commit) begin
        log_count <= log_count_next;
        cov_total <= cov_total_next;
        nd_total  <= nd_total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result.read_data     <= rdata;
      result.log_length    <= 11'(log_count_next);
      result.covered_count <= 13'(cov_total_next);
      result.nd_count      <= nd_en ? 13'(nd_total_next) : 13'd0;
      result.appended      <= append;
      result.error         <= err;
    end
  end

endmodule

// ===== rtl/pc_trace_recorder_with_filter.sv =====
// Top level of the trace recorder with coverage and nondeterminism filter.
// Depends on ptr_pkg, ptr_ctrl and ptr_datapath.
//
// Usage:
//   item channel (item_valid/item_ready/item) carries one event word:
//   record a point, mark a point nondeterministic, clear the log or read
//   one log entry. Every word gives one result word on the result channel
//   (result_valid/result_ready/result) with the log length, the covered
//   and nondeterministic counts, the appended flag and the error flag.
//   Configuration: cfg_we/cfg_index/cfg_data write trace, coverage and
//   filter enables; write only while the block is idle.
//   Sequence: the accept cycle reads the bitmap memory and the log memory
//   into registers; the commit that follows, which waits while the result
//   register is held, updates the bitmap, the log and the counters and
//   loads the result register. A new item is accepted only after the
//   previous one has committed.
//   Reset: all enables and counters go to zero, then a clearing pass
//   zeroes every entry of the bitmap memory; item_ready is low meanwhile.
//   Stall: a held result does not block the next accept; that item waits
//   in its update cycle until the result register is taken.
module pc_trace_recorder_with_filter
  import ptr_pkg::*;
#(
  parameter int NUM_POINTS = 4096,
  parameter int LOG_DEPTH  = 1024
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic       cfg_data,
  input  logic       item_valid,
  output logic       item_ready,
  input  in_word_t   item,
  output logic       result_valid,
  input  logic       result_ready,
  output out_word_t  result
);

  cmd_t  cmd;
  stat_t stat;

  ptr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  ptr_datapath #(
    .NUM_POINTS (NUM_POINTS),
    .LOG_DEPTH  (LOG_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_wr |-> !(item_valid && item_ready))
    else $error("item accepted during clearing pass");

  a_commit_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!result_valid || result_ready))
    else $error("result register overwritten");

  a_commit_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> result_valid)
    else $error("commit without result");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (32'(result.log_length) <= LOG_DEPTH))
    else $error("log length beyond depth");

  a_append_no_error: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.appended) |-> !result.error)
    else $error("append flagged with error");

endmodule
